/* design/qrs_pkg.sv */
// Package for the quadratic root solver: widths, status codes and the
// transaction and job struct types. No dependencies.
package qrs_pkg;

  localparam int COEF_W = 16;
  localparam int FRAC_W = 16;
  localparam int OUT_W  = 40;
  localparam int D_W    = 2 * COEF_W + 2;
  localparam int MAG_W  = D_W - 1;
  localparam int ROOT_W = (MAG_W + 2 * FRAC_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NB_W   = COEF_W + 1 + FRAC_W;
  localparam int DEN_W  = COEF_W + 1;
  localparam int NUM_W  = ((NB_W > ROOT_W) ? NB_W : ROOT_W) + 2;
  localparam int Q_W    = NUM_W - 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = PTR_W + 1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NEG   = 2'd1;
  localparam logic [1:0] ST_AZERO = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] plus_root_real;
    logic signed [OUT_W-1:0] plus_root_imag;
    logic signed [OUT_W-1:0] minus_root_real;
    logic signed [OUT_W-1:0] minus_root_imag;
    logic [1:0]              status;
  } qrs_out_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic signed [NB_W-1:0]  nb;
    logic signed [DEN_W-1:0] den;
  } qrs_job_t;

endpackage

/* design/qrs_front.sv */
// Front end: accepts coefficients, forms the discriminant and classifies.
// Depends on qrs_pkg.
module qrs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  qrs_pkg::qrs_in_t  coef_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  output logic              job_valid_o,
  output qrs_pkg::qrs_job_t job_o
);
  import qrs_pkg::*;

  logic                      ro_q;
  logic                      v1_q;
  logic signed [COEF_W-1:0]  a_q, b_q;
  logic signed [2*COEF_W-1:0] bb_q, ac_q;
  logic signed [D_W-1:0]     d;
  logic [D_W-1:0]            dabs;
  logic signed [DEN_W-1:0]   bn;
  logic                      v2_q;
  qrs_job_t                  job_d, job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ro_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ro_q <= cfg_wdata_i;
      end
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= coef_i.coef_a;
    b_q   <= coef_i.coef_b;
    bb_q  <= coef_i.coef_b * coef_i.coef_b;
    ac_q  <= coef_i.coef_a * coef_i.coef_c;
    job_q <= job_d;
  end

  always_comb begin
    d    = {{(D_W-2*COEF_W){bb_q[2*COEF_W-1]}}, bb_q} - {ac_q, 2'b00};
    dabs = d[D_W-1] ? -d : d;
    bn   = -{a_q[COEF_W-1] & 1'b0 | b_q[COEF_W-1], b_q};
    job_d.neg = d[D_W-1];
    job_d.mag = dabs[MAG_W-1:0];
    job_d.nb  = {bn, {FRAC_W{1'b0}}};
    job_d.den = {a_q, 1'b0};
    if (a_q == '0) begin
      job_d.status = ST_AZERO;
    end else if (d[D_W-1] && ro_q) begin
      job_d.status = ST_NEG;
    end else begin
      job_d.status = ST_OK;
    end
  end

  assign job_valid_o = v2_q;
  assign job_o       = job_q;

endmodule

/* design/qrs_fifo.sv */
// Short job queue between front and back end.
// Depends on qrs_pkg.
module qrs_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qrs_pkg::qrs_job_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output qrs_pkg::qrs_job_t data_o,
  output logic              busy_o
);
  import qrs_pkg::*;

  qrs_job_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];
  assign busy_o  = (cnt_q >= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* design/qrs_back.sv */
// Back end: pipelined square root, two pipelined dividers, result register.
// Depends on qrs_pkg.
module qrs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  qrs_pkg::qrs_job_t job_i,
  output logic              valid_o,
  output qrs_pkg::qrs_out_t result_o
);
  import qrs_pkg::*;

  logic             sq_v_q    [ROOT_W+1];
  qrs_job_t         sq_job_q  [ROOT_W+1];
  logic [REM_W-1:0] sq_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root_q [ROOT_W+1];

  logic             dv_v_q    [Q_W+1];
  logic [1:0]       dv_st_q   [Q_W+1];
  logic             dv_neg_q  [Q_W+1];
  logic             dv_s1_q   [Q_W+1];
  logic             dv_s2_q   [Q_W+1];
  logic [DEN_W-1:0] dv_dm_q   [Q_W+1];
  logic [Q_W-1:0]   dv_n1_q   [Q_W+1];
  logic [Q_W-1:0]   dv_n2_q   [Q_W+1];
  logic [DEN_W-1:0] dv_r1_q   [Q_W+1];
  logic [DEN_W-1:0] dv_r2_q   [Q_W+1];
  logic [Q_W-1:0]   dv_q1_q   [Q_W+1];
  logic [Q_W-1:0]   dv_q2_q   [Q_W+1];

  logic             out_v_q;
  qrs_out_t         out_q, out_d;

  // square root pipeline, one digit pair per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_job_q[0]  <= job_i;
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [RAD_W-1:0] rad;
    logic [REM_W+1:0] remsh, trial;
    logic             take;

    always_comb begin
      rad   = {{(RAD_W-MAG_W-2*FRAC_W){1'b0}}, sq_job_q[k].mag, {(2*FRAC_W){1'b0}}};
      remsh = {sq_rem_q[k], rad[2*(ROOT_W-1-k)+1 -: 2]};
      trial = {2'b00, sq_root_q[k], 2'b01};
      take  = (remsh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_job_q[k+1]  <= sq_job_q[k];
      sq_rem_q[k+1]  <= take ? REM_W'(remsh - trial) : remsh[REM_W-1:0];
      sq_root_q[k+1] <= {sq_root_q[k][ROOT_W-2:0], take};
    end
  end

  // numerator forming
  logic signed [NUM_W-1:0] s_x, nb_x, n1, n2, n1a, n2a;
  logic signed [DEN_W-1:0] den_x;
  logic [DEN_W-1:0]        dm;

  always_comb begin
    s_x   = $signed({{(NUM_W-ROOT_W){1'b0}}, sq_root_q[ROOT_W]});
    nb_x  = NUM_W'(sq_job_q[ROOT_W].nb);
    den_x = sq_job_q[ROOT_W].den;
    n1    = sq_job_q[ROOT_W].neg ? nb_x : nb_x + s_x;
    n2    = sq_job_q[ROOT_W].neg ? s_x  : nb_x - s_x;
    n1a   = n1[NUM_W-1] ? -n1 : n1;
    n2a   = n2[NUM_W-1] ? -n2 : n2;
    dm    = den_x[DEN_W-1] ? DEN_W'(-den_x) : DEN_W'(den_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= sq_v_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_st_q[0]  <= sq_job_q[ROOT_W].status;
    dv_neg_q[0] <= sq_job_q[ROOT_W].neg;
    dv_s1_q[0]  <= n1[NUM_W-1] ^ den_x[DEN_W-1];
    dv_s2_q[0]  <= n2[NUM_W-1] ^ den_x[DEN_W-1];
    dv_dm_q[0]  <= dm;
    dv_n1_q[0]  <= n1a[Q_W-1:0];
    dv_n2_q[0]  <= n2a[Q_W-1:0];
    dv_r1_q[0]  <= '0;
    dv_r2_q[0]  <= '0;
    dv_q1_q[0]  <= '0;
    dv_q2_q[0]  <= '0;
  end

  // restoring dividers, one quotient bit per stage
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [DEN_W:0] t1, t2, dx;
    logic           k1, k2;

    always_comb begin
      dx = {1'b0, dv_dm_q[j]};
      t1 = {dv_r1_q[j], dv_n1_q[j][Q_W-1-j]};
      t2 = {dv_r2_q[j], dv_n2_q[j][Q_W-1-j]};
      k1 = (t1 >= dx);
      k2 = (t2 >= dx);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_st_q[j+1]  <= dv_st_q[j];
      dv_neg_q[j+1] <= dv_neg_q[j];
      dv_s1_q[j+1]  <= dv_s1_q[j];
      dv_s2_q[j+1]  <= dv_s2_q[j];
      dv_dm_q[j+1]  <= dv_dm_q[j];
      dv_n1_q[j+1]  <= dv_n1_q[j];
      dv_n2_q[j+1]  <= dv_n2_q[j];
      dv_r1_q[j+1]  <= k1 ? DEN_W'(t1 - dx) : t1[DEN_W-1:0];
      dv_r2_q[j+1]  <= k2 ? DEN_W'(t2 - dx) : t2[DEN_W-1:0];
      dv_q1_q[j+1]  <= {dv_q1_q[j][Q_W-2:0], k1};
      dv_q2_q[j+1]  <= {dv_q2_q[j][Q_W-2:0], k2};
    end
  end

  // sign fix-up and result assembly
  logic signed [NUM_W-1:0] q1s, q2s;
  logic signed [OUT_W-1:0] q1x, q2x;

  always_comb begin
    q1s = dv_s1_q[Q_W] ? -$signed({1'b0, dv_q1_q[Q_W]}) : $signed({1'b0, dv_q1_q[Q_W]});
    q2s = dv_s2_q[Q_W] ? -$signed({1'b0, dv_q2_q[Q_W]}) : $signed({1'b0, dv_q2_q[Q_W]});
    q1x = OUT_W'(q1s);
    q2x = OUT_W'(q2s);
    out_d.status = dv_st_q[Q_W];
    out_d.plus_root_real  = '0;
    out_d.plus_root_imag  = '0;
    out_d.minus_root_real = '0;
    out_d.minus_root_imag = '0;
    if (dv_st_q[Q_W] == ST_OK) begin
      out_d.plus_root_real = q1x;
      if (dv_neg_q[Q_W]) begin
        out_d.minus_root_real = q1x;
        out_d.plus_root_imag  = q2x;
        out_d.minus_root_imag = -q2x;
      end else begin
        out_d.minus_root_real = q2x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_v_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o  = out_v_q;
  assign result_o = out_q;

endmodule

/* design/quadratic_root_solver_top.sv */
// Throughput: one transaction per cycle; the square root and both dividers
// are fully pipelined, one digit per stage, so busy stays low in operation.
// Reset clears all valid bits, the job queue and real_only_mode.
// Results cannot be stalled; each is presented for exactly one cycle.
// Top level: front end, job queue and back end. Depends on qrs_pkg and
// the qrs_front, qrs_fifo and qrs_back modules.
module quadratic_root_solver_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  qrs_pkg::qrs_in_t  coef_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  output logic              result_valid_o,
  output qrs_pkg::qrs_out_t result_o
);
  import qrs_pkg::*;

  logic     accept;
  logic     job_valid;
  qrs_job_t job;
  logic     q_valid;
  qrs_job_t q_job;

  assign accept = start && !busy;

  qrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .coef_i      (coef_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  qrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job),
    .pop_i   (1'b1),
    .valid_o (q_valid),
    .data_o  (q_job),
    .busy_o  (busy)
  );

  qrs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .job_i    (q_job),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != ST_OK |->
      result_o.plus_root_real == '0 && result_o.plus_root_imag == '0 &&
      result_o.minus_root_real == '0 && result_o.minus_root_imag == '0)
    else $error("error status with nonzero roots");

  a_conj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.plus_root_imag != '0 |->
      result_o.minus_root_real == result_o.plus_root_real &&
      result_o.minus_root_imag == -result_o.plus_root_imag)
    else $error("complex roots not a conjugate pair");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.status != 2'd3)
    else $error("status code out of range");

  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("job queue backed up");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for quadratic_root_solver_top: directed table plus random coefficient
// sets, checked against an in-bench root predictor. Depends on qrs_pkg and the RTL.
module tb_top;
  import qrs_pkg::*;

  localparam int LATENCY   = 72;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 1630;

  typedef struct {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    bit          known;
    qrs_out_t    res;
  } coef_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  qrs_in_t  coef_i;
  logic     cfg_we_i;
  logic     cfg_wdata_i;
  logic     result_valid_o;
  qrs_out_t result_o;

  qrs_out_t  root_q[$];
  bit        real_only;
  int        errors;
  int        cycles;
  int        idle_pct;
  coef_row_t rows[$];

  quadratic_root_solver_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .coef_i         (coef_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [OUT_W-1:0] clamp_part(longint v);
    longint hi;
    hi = (longint'(1) <<< (OUT_W - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[OUT_W-1:0];
  endfunction

  function automatic longint fixed_sqrt(longint mag);
    logic [127:0] rad;
    logic [127:0] rem;
    logic [127:0] trial;
    longint       root;
    rad  = 128'(mag) << (2 * FRAC_W);
    rem  = '0;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
      trial = (128'(root) << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic qrs_out_t solve_roots(qrs_in_t x, bit ro);
    qrs_out_t r;
    longint   a, b, c, d, s, nb, den;
    a = longint'(x.coef_a);
    b = longint'(x.coef_b);
    c = longint'(x.coef_c);
    r = '0;
    if (a == 0) begin
      r.status = ST_AZERO;
    end else begin
      d = b * b - 4 * a * c;
      if (d < 0 && ro) begin
        r.status = ST_NEG;
      end else begin
        s   = fixed_sqrt(d < 0 ? -d : d);
        nb  = -b * (longint'(1) <<< FRAC_W);
        den = 2 * a;
        r.status = ST_OK;
        if (d < 0) begin
          r.plus_root_real  = clamp_part(nb / den);
          r.minus_root_real = clamp_part(nb / den);
          r.plus_root_imag  = clamp_part(s / den);
          r.minus_root_imag = clamp_part(-(s / den));
        end else begin
          r.plus_root_real  = clamp_part((nb + s) / den);
          r.minus_root_real = clamp_part((nb - s) / den);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    qrs_out_t want;
    if (rst_ni && result_valid_o) begin
      if (root_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, result_o);
      end else begin
        want = root_q.pop_front();
        if (result_o.plus_root_real !== want.plus_root_real)
          $display("%0t: plus_root_real exp %h got %h", $time,
                   want.plus_root_real, result_o.plus_root_real);
        if (result_o.plus_root_imag !== want.plus_root_imag)
          $display("%0t: plus_root_imag exp %h got %h", $time,
                   want.plus_root_imag, result_o.plus_root_imag);
        if (result_o.minus_root_real !== want.minus_root_real)
          $display("%0t: minus_root_real exp %h got %h", $time,
                   want.minus_root_real, result_o.minus_root_real);
        if (result_o.minus_root_imag !== want.minus_root_imag)
          $display("%0t: minus_root_imag exp %h got %h", $time,
                   want.minus_root_imag, result_o.minus_root_imag);
        if (result_o.status !== want.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, result_o.status);
        if (result_o !== want) errors++;
      end
    end
  end

  task automatic drain_roots();
    while (root_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic write_mode(bit v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    real_only = v;
  endtask

  // Hold start across the accepting edge; drop it only when idling follows.
  task automatic send_coefs(qrs_in_t x, bit known, qrs_out_t res);
    qrs_out_t want;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    coef_i <= x;
    do @(posedge clk_i); while (busy);
    want = known ? res : solve_roots(x, real_only);
    if (known && want !== solve_roots(x, real_only)) begin
      errors++;
      $display("%0t: table row exp %h predictor %h", $time, want, solve_roots(x, real_only));
    end
    root_q.push_back(want);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(8)) - 16'd4;
      3: return 16'($urandom_range(200)) - 16'd100;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_row(logic [15:0] a, logic [15:0] b, logic [15:0] c, bit known,
                         qrs_out_t res);
    coef_row_t r;
    r.a = a; r.b = b; r.c = c; r.known = known; r.res = res;
    rows.push_back(r);
  endtask

  initial begin
    qrs_out_t z;
    qrs_out_t az;
    qrs_out_t ng;
    qrs_in_t  x;
    z  = '0;
    az = '0;
    az.status = ST_AZERO;
    ng = '0;
    ng.status = ST_NEG;
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    real_only = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    coef_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    add_row(16'd0, 16'd0, 16'd0, 1, az);
    add_row(16'd0, 16'h7fff, 16'h8000, 1, az);
    add_row(16'd1, 16'd0, 16'd0, 1, z);
    add_row(16'd1, 16'd0, 16'hffff, 0, z);
    add_row(16'd1, 16'd0, 16'd1, 0, z);
    add_row(16'd1, 16'hfffd, 16'd2, 0, z);
    add_row(16'h7fff, 16'h7fff, 16'h7fff, 0, z);
    add_row(16'h8000, 16'h8000, 16'h8000, 0, z);
    add_row(16'h8000, 16'h7fff, 16'h7fff, 0, z);
    add_row(16'h7fff, 16'h8000, 16'h8000, 0, z);
    add_row(16'hffff, 16'h8000, 16'h7fff, 0, z);
    add_row(16'd1, 16'h8000, 16'h8000, 0, z);
    add_row(16'hffff, 16'd1, 16'hffff, 0, z);
    add_row(16'd3, 16'd5, 16'd7, 0, z);
    add_row(16'h5555, 16'haaaa, 16'h5555, 0, z);
    add_row(16'haaaa, 16'h5555, 16'haaaa, 0, z);
    foreach (rows[i]) begin
      x.coef_a = rows[i].a; x.coef_b = rows[i].b; x.coef_c = rows[i].c;
      send_coefs(x, rows[i].known, rows[i].res);
    end
    start <= 1'b0;
    drain_roots();
    write_mode(1'b1);
    add_row(16'd1, 16'd0, 16'd1, 1, ng);
    add_row(16'h7fff, 16'd0, 16'h7fff, 1, ng);
    add_row(16'd0, 16'd0, 16'd1, 1, az);
    add_row(16'd1, 16'd2, 16'd1, 0, z);
    for (int i = 16; i < rows.size(); i++) begin
      x.coef_a = rows[i].a; x.coef_b = rows[i].b; x.coef_c = rows[i].c;
      send_coefs(x, rows[i].known, rows[i].res);
    end
    start <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      drain_roots();
      write_mode(ph[0]);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 19;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < N_RANDOM / 8; n++) begin
        x.coef_a = rand_coef();
        x.coef_b = rand_coef();
        x.coef_c = rand_coef();
        send_coefs(x, 0, z);
      end
      start <= 1'b0;
    end
    start <= 1'b0;
    drain_roots();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
